@@ rtl/bvm_pkg.sv @@
`default_nettype none
package bvm_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;
    localparam int MV_BITS        = 13;
    localparam int PCT_BITS       = 7;

    // Numerator of the curve interpolation always stays below 2^13
    localparam int CURVE_NUM_BITS = 13;
    // Twice the widest curve segment fits in this many bits
    localparam int CURVE_DIV_BITS = 11;

    localparam int CURVE_POINTS = 12;
    localparam int SEG_BITS     = $clog2(CURVE_POINTS);

    localparam logic [11:0]        PIN_SPAN_MV    = 12'd3300;
    localparam logic [MV_BITS-1:0] SUPPLY_MAX_MV  = 13'd6000;
    localparam logic [MV_BITS-1:0] EMPTY_MV       = 13'd3270;
    localparam logic [MV_BITS-1:0] LIMIT_BASE_MV  = 13'd3840;
    localparam logic [4:0]         LIMIT_STEP_MAX = 5'd23;
    localparam logic [MV_BITS-1:0] BATTERY_RST_MV = 13'd4200;
    localparam logic [PCT_BITS-1:0] PCT_FULL      = 7'd100;
    localparam logic [PCT_BITS-1:0] PCT_EMPTY     = 7'd0;

    localparam logic [MV_BITS-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd3270, 13'd3610, 13'd3690, 13'd3710, 13'd3730, 13'd3750,
        13'd3770, 13'd3790, 13'd3820, 13'd3870, 13'd3940, 13'd4200
    };

    localparam logic [PCT_BITS-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
        7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
    };

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DIVIDER_RATIO  = 3'd0,
        CFG_CHARGE_LIMIT   = 3'd1,
        CFG_USB_THRESHOLD  = 3'd2,
        CFG_LOW_BATTERY    = 3'd3,
        CFG_CHARGE_SUPPR   = 3'd4
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PIN,
        S_PIN_WAIT,
        S_SCALE,
        S_UPDATE,
        S_EVAL,
        S_SEG,
        S_CURVE,
        S_CURVE_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic pin_start;
        logic pin_fold;
        logic div_start;
        logic scale;
        logic update;
        logic eval;
        logic seg;
        logic curve_set;
        logic curve_done;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic pin_busy;
        logic div_busy;
        logic bat_low;
        logic bat_above;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/bvm_div.sv @@
`default_nettype none
module bvm_div #(
    parameter int DW = 13,
    parameter int VW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_busy,
    output logic [DW-1:0]      o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_count;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dsr;
    logic [VW:0]   w_trial;

    // restoring divide, one quotient bit per cycle
    assign w_trial = {r_rem, r_q[DW-1]} - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= CW'(DW);
        end else if (r_busy) begin
            r_count <= r_count - 1'b1;
            if (r_count == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            if (!w_trial[VW]) begin
                r_rem <= w_trial[VW-1:0];
                r_q   <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[VW-2:0], r_q[DW-1]};
                r_q   <= {r_q[DW-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

@@ rtl/bvm_datapath.sv @@
`default_nettype none
module bvm_datapath #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bvm_pkg::t_cmd                     i_cmd,
    output bvm_pkg::t_stat                         o_stat,
    input  wire logic [SAMPLE_BITS-1:0]            i_raw_sample,
    input  wire logic                              i_read_ok,
    input  wire logic                              i_out_stall,
    input  wire logic                              i_cfg_we,
    input  wire logic [bvm_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [bvm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                                   o_out_valid,
    output logic [bvm_pkg::MV_BITS-1:0]            o_supply_mv,
    output logic [bvm_pkg::MV_BITS-1:0]            o_battery_mv,
    output logic [bvm_pkg::PCT_BITS-1:0]           o_charge_pct,
    output logic                                   o_usb_present,
    output logic                                   o_shutdown_request,
    output logic                                   o_charging,
    output logic                                   o_charge_done,
    output logic                                   o_sample_valid
);
    import bvm_pkg::*;

    localparam int PW = $bits(PIN_SPAN_MV);
    localparam int DW = SAMPLE_BITS + PW;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

    // configuration
    logic [7:0]         r_ratio;
    logic [4:0]         r_limit_step;
    logic [MV_BITS-1:0] r_usb_thr;
    logic [MV_BITS-1:0] r_low_mv;
    logic               r_suppr;

    // held state
    logic [MV_BITS-1:0] r_held_sup;
    logic [MV_BITS-1:0] r_held_bat;
    logic               r_seen;

    // per item
    logic [SAMPLE_BITS-1:0] r_raw;
    logic                   r_ok;
    logic [DW-1:0]          r_fold;
    logic [PW-1:0]          r_pin;
    logic [19:0]            r_scaled;
    logic [MV_BITS-1:0]     r_bat;
    logic                   r_usb;
    logic                   r_shut;
    logic                   r_chg;
    logic [MV_BITS-1:0]     r_pv;
    logic [MV_BITS-1:0]     r_range;
    logic [PCT_BITS-1:0]    r_dp;
    logic [PCT_BITS-1:0]    r_pct0;
    logic                   r_low;
    logic                   r_above;
    logic [PCT_BITS-1:0]    r_pct;

    // output register
    logic                   r_out_valid;
    logic [MV_BITS-1:0]     r_o_sup;
    logic [MV_BITS-1:0]     r_o_bat;
    logic [PCT_BITS-1:0]    r_o_pct;
    logic                   r_o_usb;
    logic                   r_o_shut;
    logic                   r_o_chg;
    logic                   r_o_done;
    logic                   r_o_ok;

    logic [PW-1:0]             w_fold_hi;
    logic [SAMPLE_BITS-1:0]    w_fold_lo;
    logic [PW-1:0]             w_pin;
    logic [CURVE_DIV_BITS-1:0] w_div_dsr;
    logic [CURVE_NUM_BITS-1:0] w_quo;
    logic                      w_div_busy;
    logic [15:0]               w_sup_full;
    logic [MV_BITS-1:0]        w_sup;
    logic [4:0]                w_step;
    logic [MV_BITS-1:0]        w_limit;
    logic                      w_usb;
    logic [MV_BITS-1:0]        w_bat;
    logic [SEG_BITS-1:0]       w_seg;
    logic [SEG_BITS-1:0]       w_seg_prev;
    logic [MV_BITS-1:0]        w_diff;
    logic [20:0]               w_num_full;
    logic [CURVE_NUM_BITS-1:0] w_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio      <= 8'd48;
            r_limit_step <= 5'd22;
            r_usb_thr    <= 13'd4600;
            r_low_mv     <= 13'd3350;
            r_suppr      <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DIVIDER_RATIO: r_ratio      <= i_cfg_data[7:0];
                CFG_CHARGE_LIMIT:  r_limit_step <= i_cfg_data[4:0];
                CFG_USB_THRESHOLD: r_usb_thr    <= i_cfg_data[MV_BITS-1:0];
                CFG_LOW_BATTERY:   r_low_mv     <= i_cfg_data[MV_BITS-1:0];
                CFG_CHARGE_SUPPR:  r_suppr      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // divide by 2^n - 1: x = hi * 2^n + lo = hi * (2^n - 1) + (hi + lo),
    // so fold hi into the quotient until the remainder fits in n bits
    assign w_fold_hi = r_fold[DW-1:SAMPLE_BITS];
    assign w_fold_lo = r_fold[SAMPLE_BITS-1:0];
    assign w_pin     = r_pin + PW'(w_fold_lo == FULL_SCALE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pin_start) begin
            r_fold <= DW'(r_raw) * DW'(PIN_SPAN_MV);
            r_pin  <= '0;
        end else if (i_cmd.pin_fold) begin
            r_fold <= DW'(w_fold_lo) + DW'(w_fold_hi);
            r_pin  <= r_pin + w_fold_hi;
        end
    end

    // curve interpolation divide
    assign w_div_dsr = {r_range[CURVE_DIV_BITS-2:0], 1'b0};

    bvm_div #(
        .DW(CURVE_NUM_BITS),
        .VW(CURVE_DIV_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(w_num),
        .i_divisor (w_div_dsr),
        .o_busy    (w_div_busy),
        .o_quotient(w_quo)
    );

    assign w_sup_full = r_scaled[19:4];
    assign w_sup      = (w_sup_full > 16'(SUPPLY_MAX_MV)) ? SUPPLY_MAX_MV
                                                          : w_sup_full[MV_BITS-1:0];
    assign w_step     = (r_limit_step > LIMIT_STEP_MAX) ? LIMIT_STEP_MAX : r_limit_step;
    assign w_limit    = LIMIT_BASE_MV + MV_BITS'({w_step, 4'b0000});

    assign w_usb = (r_held_sup >= r_usb_thr);
    always_comb begin
        if (!r_ok) begin
            w_bat = '0;
        end else if (w_usb) begin
            w_bat = r_held_bat;
        end else begin
            w_bat = r_held_sup;
        end
    end

    // first curve point at or above the battery voltage
    always_comb begin
        w_seg = SEG_BITS'(CURVE_POINTS - 1);
        for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
            if (r_bat <= CURVE_MV[i]) begin
                w_seg = SEG_BITS'(i);
            end
        end
    end
    assign w_seg_prev = w_seg - 1'b1;

    // 2 * (v - pv) * dp + range, rounds the quotient half up
    assign w_diff     = r_bat - r_pv;
    assign w_num_full = ((21'(w_diff) * 21'(r_dp)) << 1) + 21'(r_range);
    assign w_num      = w_num_full[CURVE_NUM_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_sup <= '0;
            r_held_bat <= BATTERY_RST_MV;
            r_seen     <= 1'b0;
        end else if (i_cmd.update) begin
            r_held_sup <= w_sup;
            if (w_sup < r_usb_thr) begin
                r_seen <= 1'b1;
                if (w_sup < EMPTY_MV) begin
                    r_held_bat <= EMPTY_MV;
                end else if (w_sup > w_limit) begin
                    r_held_bat <= w_limit;
                end else begin
                    r_held_bat <= w_sup;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_raw <= i_raw_sample;
            r_ok  <= i_read_ok;
        end
        if (i_cmd.scale) begin
            r_scaled <= 20'(w_pin) * 20'(r_ratio);
        end
        if (i_cmd.eval) begin
            r_usb  <= w_usb;
            r_bat  <= w_bat;
            r_shut <= !w_usb && (w_bat != '0) && (w_bat <= r_low_mv);
            r_chg  <= w_usb && !r_suppr;
        end
        if (i_cmd.seg) begin
            r_pv    <= CURVE_MV[w_seg_prev];
            r_range <= CURVE_MV[w_seg] - CURVE_MV[w_seg_prev];
            r_dp    <= CURVE_PCT[w_seg] - CURVE_PCT[w_seg_prev];
            r_pct0  <= CURVE_PCT[w_seg_prev];
            r_low   <= (r_bat <= CURVE_MV[0]);
            r_above <= (r_bat > CURVE_MV[CURVE_POINTS-1]);
        end
        if (i_cmd.curve_set) begin
            r_pct <= r_above ? PCT_FULL : PCT_EMPTY;
        end else if (i_cmd.curve_done) begin
            r_pct <= r_pct0 + w_quo[PCT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_sup  <= r_held_sup;
            r_o_bat  <= r_bat;
            r_o_pct  <= r_pct;
            r_o_usb  <= r_usb;
            r_o_shut <= r_shut;
            r_o_chg  <= r_chg;
            r_o_done <= r_seen && r_chg && (r_pct == PCT_FULL);
            r_o_ok   <= r_ok;
        end
    end

    always_comb begin
        o_stat.ok        = r_ok;
        o_stat.pin_busy  = (w_fold_hi != '0);
        o_stat.div_busy  = w_div_busy;
        o_stat.bat_low   = r_low;
        o_stat.bat_above = r_above;
        o_stat.out_busy  = r_out_valid && i_out_stall;
    end

    assign o_out_valid        = r_out_valid;
    assign o_supply_mv        = r_o_sup;
    assign o_battery_mv       = r_o_bat;
    assign o_charge_pct       = r_o_pct;
    assign o_usb_present      = r_o_usb;
    assign o_shutdown_request = r_o_shut;
    assign o_charging         = r_o_chg;
    assign o_charge_done      = r_o_done;
    assign o_sample_valid     = r_o_ok;

endmodule
`default_nettype wire

@@ rtl/bvm_ctrl.sv @@
`default_nettype none
module bvm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire bvm_pkg::t_stat i_stat,
    output logic                o_in_stall,
    output bvm_pkg::t_cmd       o_cmd
);
    import bvm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (i_in_valid) n_state = S_PIN;
            S_PIN:        n_state = i_stat.ok ? S_PIN_WAIT : S_EVAL;
            S_PIN_WAIT:   if (!i_stat.pin_busy) n_state = S_SCALE;
            S_SCALE:      n_state = S_UPDATE;
            S_UPDATE:     n_state = S_EVAL;
            S_EVAL:       n_state = S_SEG;
            S_SEG:        n_state = S_CURVE;
            S_CURVE: begin
                if (i_stat.bat_low || i_stat.bat_above) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_CURVE_WAIT;
                end
            end
            S_CURVE_WAIT: if (!i_stat.div_busy) n_state = S_FINISH;
            S_FINISH:     if (!i_stat.out_busy) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:     o_cmd.accept = i_in_valid;
            S_PIN:      o_cmd.pin_start = i_stat.ok;
            S_PIN_WAIT: o_cmd.pin_fold = i_stat.pin_busy;
            S_SCALE:    o_cmd.scale = 1'b1;
            S_UPDATE:   o_cmd.update = 1'b1;
            S_EVAL:     o_cmd.eval = 1'b1;
            S_SEG:      o_cmd.seg = 1'b1;
            S_CURVE: begin
                if (i_stat.bat_low || i_stat.bat_above) begin
                    o_cmd.curve_set = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                end
            end
            S_CURVE_WAIT: o_cmd.curve_done = !i_stat.div_busy;
            S_FINISH:     o_cmd.load_out = !i_stat.out_busy;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/battery_voltage_monitor_unit.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_raw_sample, i_read_ok
// result    out        o_out_valid / i_out_stall supply, battery, percent, flags
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item at a time. A good sample goes through accept, load, the steps folding
// the divide by the ADC full scale, scaling, held state and curve lookup, the
// bit-serial curve interpolation and a last step to load the output register.
// Below the first or above the last curve point the interpolation is skipped; a
// failed read also skips folding, scaling and the held-state update.
// Reset is synchronous; it restores register defaults and held state. A new
// sample is taken while a result still waits on a stalled output; the next
// result waits in the final state until that transfer.
`default_nettype none
module battery_voltage_monitor_unit #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]             i_raw_sample,
    input  wire logic                               i_read_ok,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [bvm_pkg::MV_BITS-1:0]             o_supply_mv,
    output logic [bvm_pkg::MV_BITS-1:0]             o_battery_mv,
    output logic [bvm_pkg::PCT_BITS-1:0]            o_charge_pct,
    output logic                                    o_usb_present,
    output logic                                    o_shutdown_request,
    output logic                                    o_charging,
    output logic                                    o_charge_done,
    output logic                                    o_sample_valid,
    input  wire logic                               i_cfg_we,
    input  wire logic [bvm_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [bvm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import bvm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    bvm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (w_stat),
        .o_in_stall(o_in_stall),
        .o_cmd     (w_cmd)
    );

    bvm_datapath #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_raw_sample      (i_raw_sample),
        .i_read_ok         (i_read_ok),
        .i_out_stall       (i_out_stall),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .o_supply_mv       (o_supply_mv),
        .o_battery_mv      (o_battery_mv),
        .o_charge_pct      (o_charge_pct),
        .o_usb_present     (o_usb_present),
        .o_shutdown_request(o_shutdown_request),
        .o_charging        (o_charging),
        .o_charge_done     (o_charge_done),
        .o_sample_valid    (o_sample_valid)
    );

endmodule
`default_nettype wire
